>>> design/fda_pkg.sv
// Shared types and constants of the flow delta accumulator.
package fda_pkg;

    localparam int DeltaWidth = 16;
    localparam int TurnWidth  = DeltaWidth + 1;
    localparam int CountWidth = 32;
    localparam int TimeWidth  = 32;
    localparam int QualWidth  = 8;
    localparam int CfgIdxWidth  = 2;
    localparam int CfgDataWidth = 2;

    localparam logic [CfgIdxWidth-1:0] CFG_SWAP_AXES = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_ROTATION  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_NEGATE_X  = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_NEGATE_Y  = 2'd3;

    localparam logic OP_MOTION  = 1'b0;
    localparam logic OP_PUBLISH = 1'b1;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic                          operation;
        logic                          motion_flag;
        logic signed [DeltaWidth-1:0]  delta_x;
        logic signed [DeltaWidth-1:0]  delta_y;
        logic [QualWidth-1:0]          sample_quality;
        logic [TimeWidth-1:0]          time_now;
        logic                          sensor_ready;
    } request_t;

    typedef struct packed {
        logic [TimeWidth-1:0]          stamp_us;
        logic [TimeWidth-1:0]          window_us;
        logic signed [CountWidth-1:0]  count_x;
        logic signed [CountWidth-1:0]  count_y;
        logic [QualWidth-1:0]          published_quality;
        logic                          sample_valid;
    } result_t;

    typedef struct packed {
        logic                          publish;
        logic signed [TurnWidth-1:0]   step_x;
        logic signed [TurnWidth-1:0]   step_y;
        logic [QualWidth-1:0]          quality;
        logic [TimeWidth-1:0]          time_now;
        logic                          ready;
    } cmd_t;

    typedef struct packed {
        logic       swap_axes;
        logic [1:0] rotation;
        logic       negate_x;
        logic       negate_y;
    } orient_cfg_t;

endpackage

>>> design/fda_queue.sv
// Small register queue used between the front and back and for results.
module fda_queue
    import fda_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    store_reg [DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CntWidth'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/fda_front.sv
// Front part: holds the mounting configuration, drops idle reports and reorients deltas.
module fda_front
    import fda_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    push,
    input  request_t                request,
    output logic                    cmd_push,
    output cmd_t                    cmd
);

    orient_cfg_t cfg_reg, cfg_next;
    logic signed [TurnWidth-1:0] a_raw, b_raw;
    logic signed [TurnWidth-1:0] a_swp, b_swp;
    logic signed [TurnWidth-1:0] a_rot, b_rot;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SWAP_AXES: cfg_next.swap_axes = cfg_data[0];
                CFG_ROTATION:  cfg_next.rotation  = cfg_data[1:0];
                CFG_NEGATE_X:  cfg_next.negate_x  = cfg_data[0];
                CFG_NEGATE_Y:  cfg_next.negate_y  = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        a_raw = TurnWidth'(request.delta_x);
        b_raw = TurnWidth'(request.delta_y);
        a_swp = cfg_reg.swap_axes ? b_raw : a_raw;
        b_swp = cfg_reg.swap_axes ? a_raw : b_raw;
        unique case (cfg_reg.rotation)
            ROT_90:
            begin
                a_rot = -b_swp;
                b_rot = a_swp;
            end
            ROT_180:
            begin
                a_rot = -a_swp;
                b_rot = -b_swp;
            end
            ROT_270:
            begin
                a_rot = b_swp;
                b_rot = -a_swp;
            end
            default:
            begin
                a_rot = a_swp;
                b_rot = b_swp;
            end
        endcase
    end

    assign cmd.publish  = (request.operation == OP_PUBLISH);
    assign cmd.step_x   = cfg_reg.negate_x ? -a_rot : a_rot;
    assign cmd.step_y   = cfg_reg.negate_y ? -b_rot : b_rot;
    assign cmd.quality  = request.sample_quality;
    assign cmd.time_now = request.time_now;
    assign cmd.ready    = request.sensor_ready;

    // A motion report without movement leaves no trace at all.
    assign cmd_push = push && ((request.operation == OP_PUBLISH) || request.motion_flag);

endmodule

>>> design/fda_back.sv
// Back part: saturating accumulators, window timing and result formation.
module fda_back
    import fda_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_empty,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res
);

    logic signed [CountWidth-1:0] sum_x_reg, sum_x_next;
    logic signed [CountWidth-1:0] sum_y_reg, sum_y_next;
    logic [QualWidth-1:0]         quality_reg, quality_next;
    logic [TimeWidth-1:0]         start_reg, start_next;

    function automatic logic signed [CountWidth-1:0] sat_add(
        input logic signed [CountWidth-1:0] acc,
        input logic signed [TurnWidth-1:0]  step
    );
        logic signed [CountWidth:0] total;
        logic signed [CountWidth:0] hi;
        logic signed [CountWidth:0] lo;
        begin
            hi    = (CountWidth + 1)'({1'b0, {(CountWidth - 1){1'b1}}});
            lo    = (CountWidth + 1)'({2'b11, {(CountWidth - 1){1'b0}}});
            total = (CountWidth + 1)'(acc) + (CountWidth + 1)'(step);
            if (total > hi)
            begin
                sat_add = hi[CountWidth-1:0];
            end
            else if (total < lo)
            begin
                sat_add = lo[CountWidth-1:0];
            end
            else
            begin
                sat_add = total[CountWidth-1:0];
            end
        end
    endfunction

    assign cmd_pop  = !cmd_empty && (!cmd.publish || !res_full);
    assign res_push = cmd_pop && cmd.publish;

    assign res.stamp_us          = cmd.time_now;
    assign res.window_us         = cmd.time_now - start_reg;
    assign res.count_x           = sum_x_reg;
    assign res.count_y           = sum_y_reg;
    assign res.published_quality = quality_reg;
    assign res.sample_valid      = cmd.ready;

    always_comb
    begin
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        quality_next = quality_reg;
        start_next   = start_reg;
        if (cmd_pop)
        begin
            if (cmd.publish)
            begin
                sum_x_next   = '0;
                sum_y_next   = '0;
                quality_next = '0;
                start_next   = cmd.time_now;
            end
            else
            begin
                sum_x_next   = sat_add(sum_x_reg, cmd.step_x);
                sum_y_next   = sat_add(sum_y_reg, cmd.step_y);
                quality_next = cmd.quality;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            quality_reg <= '0;
            start_reg   <= '0;
        end
        else
        begin
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            quality_reg <= quality_next;
            start_reg   <= start_next;
        end
    end

endmodule

>>> design/flow_delta_accumulator.sv
// Top level of the flow delta accumulator.
// A request is either a motion report or a publish request and is written with push while
// full is low. Motion reports with the motion flag set are reoriented by the swap, rotation
// and negation registers and added into two saturating 32-bit counts; those without it are
// dropped at once. A publish request yields one result with the time stamp, the window
// length, both counts, the last quality and the ready flag, and then clears the counts.
// Results wait in a two-entry queue and are taken with pop while empty is low.
// One request is accepted in every cycle while full is low. A publish request is written
// into the command queue; the back part takes the command from that queue and writes its
// result into the result queue, whose head is on the result ports. The back part takes
// a waiting command unless it is a publish command and the result queue is full.
// When pop stays low the result queue fills, publish commands then wait in the command
// queue, and full rises once that queue is full as well. Configuration writes take effect
// on the next cycle. The user must make them while the block is idle; nothing enforces it.
// Reset clears the counts, the quality, the window start, the registers and both queues.
module flow_delta_accumulator
    import fda_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    push,
    input  request_t                request,
    output logic                    full,
    input  logic                    pop,
    output result_t                 result,
    output logic                    empty
);

    logic    cmd_push, cmd_pop, cmd_empty;
    cmd_t    cmd_in, cmd_out;
    logic    res_push, res_full;
    result_t res_in;

    fda_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .request   (request),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    fda_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    fda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    fda_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (result),
        .empty     (empty)
    );

endmodule
